// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("assertion failed");

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/ppp_pkg.sv =====
package ppp_pkg;

	localparam int NUM_W     = 98;   // exact signed numerator
	localparam int NQ_W      = 82;   // |numerator| >> 16
	localparam int DEN_W     = 64;   // |camera depth|
	localparam int PIX_W     = 16;
	localparam int DIM_W     = 13;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_STEPS = PIX_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X,
		REG_FOCAL_Y,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] FOCAL_X_RST  = 32'd34917253;
	localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 32'd34912338;
	localparam logic [CFG_W-1:0] CENTER_X_RST = 32'd41428582;
	localparam logic [CFG_W-1:0] CENTER_Y_RST = 32'hFFFC926F;
	localparam logic [DIM_W-1:0] WIDTH_RST    = 13'd1280;
	localparam logic [DIM_W-1:0] HEIGHT_RST   = 13'd360;

	typedef enum logic [1:0] {
		CONE_RED,
		CONE_BLUE,
		CONE_YELLOW,
		CONE_OTHER
	} cone_t;

	// Extrinsic rotation, Q2.30
	localparam logic signed [31:0] XFORM [3][3] = '{
		'{32'sd3821899,    -32'sd1073610414, -32'sd16357776},
		'{32'sd2123975,     32'sd16365407,   -32'sd1073614999},
		'{32'sd1073732921,  32'sd3789090,     32'sd2181967}
	};

	// Translation, Q2.30 scaled to Q.46
	localparam logic signed [63:0] XOFF [3] = '{
		64'sd95860739 <<< 16,
		64'sd978184167 <<< 16,
		64'sd2056650358 <<< 16
	};

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} bgr_t;

	typedef struct packed {
		logic [NQ_W-1:0]  rem;
		logic [PIX_W-1:0] quo;
		logic             sat;
		logic             neg;
	} div_lane_t;

	typedef struct packed {
		div_lane_t        lane_u;
		div_lane_t        lane_v;
		logic [DEN_W-1:0] den;
		logic             zero;
		cone_t            color;
	} div_t;

	function automatic bgr_t cone_bgr(input cone_t c);
		bgr_t o;
		unique case (c)
			CONE_RED:    o = '{b: 8'd0,   g: 8'd0,   r: 8'd255};
			CONE_BLUE:   o = '{b: 8'd255, g: 8'd0,   r: 8'd0};
			CONE_YELLOW: o = '{b: 8'd0,   g: 8'd255, r: 8'd255};
			default:     o = '{b: 8'd255, g: 8'd255, r: 8'd255};
		endcase
		return o;
	endfunction

	// One restoring quotient bit
	function automatic div_lane_t div_step(input div_lane_t l, input logic [DEN_W-1:0] d,
			input logic [STEP_W-1:0] b);
		div_lane_t   o;
		logic [NQ_W:0] sh;
		logic [NQ_W:0] diff;
		o = l;
		sh = (NQ_W+1)'(d) << b;
		diff = {1'b0, l.rem} - sh;
		if (!diff[NQ_W]) begin
			o.rem = diff[NQ_W-1:0];
			o.quo[b] = 1'b1;
		end
		return o;
	endfunction

	// Sign and saturation of a finished lane
	function automatic logic [PIX_W-1:0] lane_pixel(input div_lane_t l);
		logic [PIX_W-1:0] o;
		if (l.neg) begin
			if (l.sat || l.quo > 16'd32768) o = 16'h8000;
			else o = 16'd0 - l.quo;
		end else begin
			if (l.sat || l.quo > 16'd32767) o = 16'h7FFF;
			else o = l.quo;
		end
		return o;
	endfunction

endpackage

// ===== rtl/ppp_div.sv =====
module ppp_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ppp_pkg::div_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ppp_pkg::div_t  out_data
);
	import ppp_pkg::*;

	div_t stg_s [DIV_STEPS];
	logic vld_s [DIV_STEPS];
	logic adv   [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam logic [STEP_W-1:0] BIT = STEP_W'(DIV_STEPS - 1 - k);
		div_t src;
		div_t nxt;
		logic src_v;

		if (k == 0) begin : g_first
			assign src   = in_data;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = stg_s[k-1];
			assign src_v = vld_s[k-1];
		end

		if (k == DIV_STEPS - 1) begin : g_last
			assign adv[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign adv[k] = !vld_s[k] || adv[k+1];
		end

		always_comb begin
			nxt        = src;
			nxt.lane_u = div_step(src.lane_u, src.den, BIT);
			nxt.lane_v = div_step(src.lane_v, src.den, BIT);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				stg_s[k] <= nxt;
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_s[DIV_STEPS-1];
	assign out_data  = stg_s[DIV_STEPS-1];

endmodule

// ===== rtl/point_to_pixel_projection_top.sv =====
// Path from input transaction to result: 9 front stages, 16 divide steps, output register.
// Throughput: one transaction per cycle unless stalled; stalls collapse bubbles stage by stage.
// Each divide stage resolves one quotient bit per lane; input is taken while a stage is empty.
// Reset (arst_n low, async): all valid bits clear, config registers return to defaults.
module point_to_pixel_projection_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ppp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [31:0]           pos_x,
	input  logic signed [31:0]           pos_y,
	input  logic signed [31:0]           pos_z,
	input  logic [1:0]                   cone_color,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [15:0]           pixel_u,
	output logic signed [15:0]           pixel_v,
	output logic                         in_view,
	output logic [7:0]                   blue_level,
	output logic [7:0]                   green_level,
	output logic [7:0]                   red_level
);
	import ppp_pkg::*;

	`include "assert_macros.svh"

	localparam int NSTG = 9;

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [DIM_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_X_RST;
			focal_y_q  <= FOCAL_Y_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FOCAL_X:      focal_x_q  <= cfg_data;
				REG_FOCAL_Y:      focal_y_q  <= cfg_data;
				REG_CENTER_X:     center_x_q <= cfg_data;
				REG_CENTER_Y:     center_y_q <= cfg_data;
				REG_IMAGE_WIDTH:  width_q    <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q   <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- front pipeline control ----------------
	// Stage k advances when empty or when the stage after it advances.
	logic vld_s [NSTG];
	logic adv   [NSTG];
	logic div_in_ready;

	for (genvar k = 0; k < NSTG; k++) begin : g_ctl
		if (k == NSTG - 1) begin : g_last
			assign adv[k] = !vld_s[k] || div_in_ready;
		end else begin : g_mid
			assign adv[k] = !vld_s[k] || adv[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				if (k == 0) vld_s[k] <= in_valid;
				else vld_s[k] <= vld_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign in_ready = adv[0];

	// s1: capture the transaction
	logic signed [31:0] pos_s1 [3];
	cone_t              col_s1;
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			col_s1    <= cone_t'(cone_color);
		end
	end

	// s2: nine 32x32 rotation products
	logic signed [63:0] prod_s2 [3][3];
	cone_t              col_s2;
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					prod_s2[i][j] <= XFORM[i][j] * pos_s1[j];
			col_s2 <= col_s1;
		end
	end

	// s3: pairwise sums, translation folded in
	logic signed [63:0] sa_s3 [3];
	logic signed [63:0] sb_s3 [3];
	cone_t              col_s3;
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < 3; i++) begin
				sa_s3[i] <= prod_s2[i][0] + prod_s2[i][1];
				sb_s3[i] <= prod_s2[i][2] + XOFF[i];
			end
			col_s3 <= col_s2;
		end
	end

	// s4: camera coordinates, Q.46
	logic signed [63:0] cam_s4 [3];
	cone_t              col_s4;
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < 3; i++)
				cam_s4[i] <= sa_s3[i] + sb_s3[i];
			col_s4 <= col_s3;
		end
	end

	// s5: intrinsic partial products, 64-bit operand split in halves
	logic [63:0]        fxl_s5, fyl_s5;
	logic signed [64:0] fxh_s5, fyh_s5, cxl_s5, cyl_s5;
	logic signed [63:0] cxh_s5, cyh_s5;
	logic signed [63:0] den_s5;
	logic               zero_s5;
	cone_t              col_s5;
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			fxl_s5  <= focal_x_q * cam_s4[0][31:0];
			fxh_s5  <= $signed({1'b0, focal_x_q}) * $signed(cam_s4[0][63:32]);
			fyl_s5  <= focal_y_q * cam_s4[1][31:0];
			fyh_s5  <= $signed({1'b0, focal_y_q}) * $signed(cam_s4[1][63:32]);
			cxl_s5  <= $signed(center_x_q) * $signed({1'b0, cam_s4[2][31:0]});
			cxh_s5  <= $signed(center_x_q) * $signed(cam_s4[2][63:32]);
			cyl_s5  <= $signed(center_y_q) * $signed({1'b0, cam_s4[2][31:0]});
			cyh_s5  <= $signed(center_y_q) * $signed(cam_s4[2][63:32]);
			den_s5  <= cam_s4[2];
			zero_s5 <= (cam_s4[2] == 64'sd0);
			col_s5  <= col_s4;
		end
	end

	// s6: recombine halves
	logic signed [NUM_W-1:0] fu_s6, cu_s6, fv_s6, cv_s6;
	logic signed [63:0]      den_s6;
	logic                    zero_s6;
	cone_t                   col_s6;
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			fu_s6   <= (NUM_W'(fxh_s5) <<< 32) + NUM_W'(fxl_s5);
			fv_s6   <= (NUM_W'(fyh_s5) <<< 32) + NUM_W'(fyl_s5);
			cu_s6   <= (NUM_W'(cxh_s5) <<< 32) + NUM_W'(cxl_s5);
			cv_s6   <= (NUM_W'(cyh_s5) <<< 32) + NUM_W'(cyl_s5);
			den_s6  <= den_s5;
			zero_s6 <= zero_s5;
			col_s6  <= col_s5;
		end
	end

	// s7: numerators fx*x + cx*z, fy*y + cy*z
	logic signed [NUM_W-1:0] nu_s7, nv_s7;
	logic signed [63:0]      den_s7;
	logic                    zero_s7;
	cone_t                   col_s7;
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			nu_s7   <= fu_s6 + cu_s6;
			nv_s7   <= fv_s6 + cv_s6;
			den_s7  <= den_s6;
			zero_s7 <= zero_s6;
			col_s7  <= col_s6;
		end
	end

	// s8: magnitudes and signs; the 2^16 scale of the divisor moves to the numerator
	logic [NUM_W-1:0] nu_mag, nv_mag;
	logic [NQ_W-1:0]  nu_s8, nv_s8;
	logic             negu_s8, negv_s8;
	logic [DEN_W-1:0] den_s8;
	logic             zero_s8;
	cone_t            col_s8;
	always_comb begin
		nu_mag = nu_s7[NUM_W-1] ? NUM_W'(-nu_s7) : NUM_W'(nu_s7);
		nv_mag = nv_s7[NUM_W-1] ? NUM_W'(-nv_s7) : NUM_W'(nv_s7);
	end
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			nu_s8   <= nu_mag[NUM_W-1:16];
			nv_s8   <= nv_mag[NUM_W-1:16];
			negu_s8 <= nu_s7[NUM_W-1] ^ den_s7[63];
			negv_s8 <= nv_s7[NUM_W-1] ^ den_s7[63];
			den_s8  <= den_s7[63] ? DEN_W'(-den_s7) : DEN_W'(den_s7);
			zero_s8 <= zero_s7;
			col_s8  <= col_s7;
		end
	end

	// s9: quotient overflow test (q >= 2^16) and divider load
	div_t div_s9;
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			div_s9.lane_u.rem <= nu_s8;
			div_s9.lane_u.quo <= '0;
			div_s9.lane_u.sat <= (nu_s8 >= {2'b00, den_s8, 16'h0000});
			div_s9.lane_u.neg <= negu_s8;
			div_s9.lane_v.rem <= nv_s8;
			div_s9.lane_v.quo <= '0;
			div_s9.lane_v.sat <= (nv_s8 >= {2'b00, den_s8, 16'h0000});
			div_s9.lane_v.neg <= negv_s8;
			div_s9.den        <= den_s8;
			div_s9.zero       <= zero_s8;
			div_s9.color      <= col_s8;
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	logic div_out_valid;
	div_t div_out;
	logic adv_out;

	ppp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s[NSTG-1]),
		.in_ready  (div_in_ready),
		.in_data   (div_s9),
		.out_valid (div_out_valid),
		.out_ready (adv_out),
		.out_data  (div_out)
	);

	// ---------------- output register ----------------
	logic             out_valid_q;
	logic [PIX_W-1:0] u_pix, v_pix;
	logic [PIX_W-1:0] u_q, v_q;
	logic             view_q;
	bgr_t             bgr_q;

	assign adv_out = !out_valid_q || out_ready;

	always_comb begin
		u_pix = div_out.zero ? '0 : lane_pixel(div_out.lane_u);
		v_pix = div_out.zero ? '0 : lane_pixel(div_out.lane_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			u_q    <= u_pix;
			v_q    <= v_pix;
			view_q <= !div_out.zero && !u_pix[PIX_W-1] && !v_pix[PIX_W-1]
				&& (u_pix < PIX_W'(width_q)) && (v_pix < PIX_W'(height_q));
			bgr_q  <= cone_bgr(div_out.color);
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_u     = u_q;
	assign pixel_v     = v_q;
	assign in_view     = view_q;
	assign blue_level  = bgr_q.b;
	assign green_level = bgr_q.g;
	assign red_level   = bgr_q.r;

	// ---------------- assertions ----------------
	// an empty first stage always takes a transaction
	`ASSERT_CLK(a_ready_when_empty, clk, arst_n, !vld_s[0] |-> in_ready)
	// a stalled front end keeps its item toward the divider
	`ASSERT_CLK(a_s9_holds, clk, arst_n, vld_s[NSTG-1] && !div_in_ready |=> vld_s[NSTG-1])
	// an in-view pixel has non-negative coordinates and u inside the configured image width
	`ASSERT_CLK(a_view_bounds, clk, arst_n,
		out_valid && in_view |-> !pixel_u[15] && !pixel_v[15] && (u_q < PIX_W'(width_q)))

endmodule
